// ----- rtl/core/pi_speed_controller_antiwindup_macros.svh -----
// Assertion macros for the PI speed controller.
// Each macro uses the clock aclk and the active-low reset aresetn of the including module.
`ifndef PI_SPEED_CONTROLLER_ANTIWINDUP_MACROS_SVH
`define PI_SPEED_CONTROLLER_ANTIWINDUP_MACROS_SVH

// A condition that holds in the same cycle as its trigger.
`define PISC_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

// A condition that holds in the cycle after its trigger.
`define PISC_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ----- rtl/core/pisc_pkg.sv -----
// Shared types and constants for the PI speed controller.
// Used by pisc_div and pi_speed_controller_antiwindup; no dependencies.
package pisc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PROP_GAIN     = 3'd0;
    localparam logic [2:0] CFG_INTEGRAL_GAIN = 3'd1;
    localparam logic [2:0] CFG_SAMPLE_PERIOD = 3'd2;
    localparam logic [2:0] CFG_DRIVE_MIN     = 3'd3;
    localparam logic [2:0] CFG_DRIVE_MAX     = 3'd4;

    // Request to the serial divider.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } pisc_div_req_t;

    // Status from the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } pisc_div_stat_t;

endpackage

// ----- rtl/core/pisc_div.sv -----
// Serial restoring divider: 32-bit unsigned dividend by 16-bit unsigned divisor.
// Depends on pisc_pkg for its request and status types.
module pisc_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  pisc_pkg::pisc_div_req_t  req,
    output pisc_pkg::pisc_div_stat_t stat,
    output logic [31:0]              quotient
);

    logic [16:0] rem_reg;
    logic [31:0] quo_reg;
    logic [15:0] dsr_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [16:0] rem_sh;
    logic        fits;

    // One quotient bit per cycle.
    assign rem_sh = {rem_reg[15:0], quo_reg[31]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dsr_reg  <= req.divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
                quo_reg <= {quo_reg[30:0], fits};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ----- rtl/core/pi_speed_controller_antiwindup.sv -----
// PI speed controller with dynamic integrator clamping, top level.
// Depends on pisc_pkg, pisc_div and pi_speed_controller_antiwindup_macros.svh.
//
// Usage:
// The s_ channel takes one request per control step: setpoint, measured speed
// and present PWM value. The m_ channel returns one result per request: the
// saturated drive and two status flags. Registers are written through the cfg_
// channel, which is always ready; the user must write them only while the block
// is idle, which the block itself does not enforce. A request passes from
// acceptance to a valid result through the serial divider that forms the error
// ratio, then a single shared multiplier used for five products in turn, plus
// add, clamp and saturate steps. s_tready rises together with m_tvalid, so the
// next request can be accepted at the following edge.
// A result waits in the output register while the receiver stalls; the next
// request may be accepted and worked on meanwhile, and it holds in its last step
// until the output register is free.
// Reset clears the integrator and the stored error and loads the register defaults.
`include "pi_speed_controller_antiwindup_macros.svh"

module pi_speed_controller_antiwindup (
    input  logic        aclk,
    input  logic        aresetn,
    // Input requests.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // target_speed[15:0], measured_speed[31:16], present_pwm[47:32]
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // drive[23:0], divide_fault[24], integrator_clamped[25], zero
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_GAIN, ST_SUM, ST_PROP, ST_PSAT,
        ST_KT, ST_KTP, ST_DELTA, ST_INTEG, ST_CLAMP, ST_DRIVE
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [23:0]        kp_reg;
    logic [23:0]        ki_reg;
    logic [19:0]        period_reg;
    logic signed [23:0] dmin_reg;
    logic signed [23:0] dmax_reg;

    // Controller state.
    logic signed [47:0] integ_reg;
    logic signed [16:0] last_err_reg;

    // Working registers of one step.
    logic signed [16:0] err_reg;
    logic [16:0]        es_abs_reg;
    logic               es_neg_reg;
    logic [15:0]        pwm_reg;
    logic               fault_reg;
    logic               rneg_reg;
    logic [31:0]        ratio_reg;
    logic [39:0]        gain_reg;
    logic signed [41:0] a_reg;
    logic [40:0]        pmag_reg;
    logic               pneg_reg;
    logic signed [23:0] prop_reg;
    logic [27:0]        kt_reg;
    logic [43:0]        ktp_reg;
    logic [51:0]        delta_reg;
    logic signed [53:0] sum_reg;
    logic signed [24:0] lhi_reg;
    logic signed [24:0] llo_reg;
    logic               clamped_reg;

    // Output register.
    logic               m_valid_reg;
    logic signed [23:0] drive_reg;
    logic               ofault_reg;
    logic               oclamp_reg;

    // Divider.
    pisc_pkg::pisc_div_req_t  div_req;
    pisc_pkg::pisc_div_stat_t div_stat;
    logic [31:0]              div_quo;

    // Request decode.
    logic signed [15:0] in_target;
    logic signed [15:0] in_meas;
    logic signed [16:0] in_err;
    logic signed [15:0] in_dsr;
    logic [16:0]        in_err_abs;
    logic [15:0]        in_dsr_abs;
    logic signed [17:0] in_es;
    logic [17:0]        in_es_abs;
    logic               accept;

    assign in_target  = s_tdata[15:0];
    assign in_meas    = s_tdata[31:16];
    assign in_err     = {in_target[15], in_target} - {in_meas[15], in_meas};
    assign in_dsr     = in_err[16] ? in_meas : in_target;
    assign in_err_abs = in_err[16] ? (17'd0 - in_err) : in_err;
    assign in_dsr_abs = in_dsr[15] ? (16'd0 - in_dsr) : in_dsr;
    assign in_es      = {in_err[16], in_err} + {last_err_reg[16], last_err_reg};
    assign in_es_abs  = in_es[17] ? (18'd0 - in_es) : in_es;
    assign accept     = s_tvalid && s_tready;

    assign div_req.start    = accept;
    assign div_req.dividend = {in_err_abs[15:0], 16'd0};
    assign div_req.divisor  = in_dsr_abs;

    pisc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // Shared multiplier, operands chosen by the sequencer step.
    logic [43:0] mul_a;
    logic [23:0] mul_b;
    logic [67:0] mul_p;
    logic [40:0] a_abs;

    assign a_abs = a_reg[41] ? 41'(42'sd0 - a_reg) : a_reg[40:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_GAIN:  begin mul_a = {12'd0, ratio_reg};  mul_b = kp_reg;               end
            ST_PROP:  begin mul_a = {3'd0, a_abs};       mul_b = {8'd0, pwm_reg};      end
            ST_KT:    begin mul_a = {20'd0, ki_reg};     mul_b = {4'd0, period_reg};   end
            ST_KTP:   begin mul_a = {16'd0, kt_reg};     mul_b = {8'd0, pwm_reg};      end
            ST_DELTA: begin mul_a = ktp_reg;             mul_b = {7'd0, es_abs_reg};   end
            default:  begin mul_a = '0;                  mul_b = '0;                   end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Step arithmetic.
    logic signed [53:0] delta_s;
    logic signed [53:0] sum_next;
    logic signed [24:0] hi_diff;
    logic signed [24:0] lo_diff;
    logic signed [53:0] hi_q;
    logic signed [53:0] lo_q;
    logic signed [47:0] integ_bias;
    logic signed [31:0] integ_int;
    logic signed [32:0] drv;
    logic signed [23:0] drv_sat;

    assign delta_s  = es_neg_reg ? (54'sd0 - $signed({2'b0, delta_reg}))
                                 : $signed({2'b0, delta_reg});
    assign sum_next = {{6{integ_reg[47]}}, integ_reg} + delta_s;
    assign hi_diff  = {dmax_reg[23], dmax_reg} - {prop_reg[23], prop_reg};
    assign lo_diff  = {dmin_reg[23], dmin_reg} - {prop_reg[23], prop_reg};
    assign hi_q     = {{13{lhi_reg[24]}}, lhi_reg, 16'd0};
    assign lo_q     = {{13{llo_reg[24]}}, llo_reg, 16'd0};

    // Integer part of the integrator, truncated toward zero.
    assign integ_bias = integ_reg + (integ_reg[47] ? 48'sd65535 : 48'sd0);
    assign integ_int  = integ_bias[47:16];
    assign drv        = {{9{prop_reg[23]}}, prop_reg} + {integ_int[31], integ_int};

    always_comb begin
        priority if (drv > $signed({{9{dmax_reg[23]}}, dmax_reg})) begin
            drv_sat = dmax_reg;
        end else if (drv < $signed({{9{dmin_reg[23]}}, dmin_reg})) begin
            drv_sat = dmin_reg;
        end else begin
            drv_sat = drv[23:0];
        end
    end

    // Sequencer with its registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            integ_reg    <= '0;
            last_err_reg <= '0;
            kp_reg       <= 24'd65536;
            ki_reg       <= 24'd0;
            period_reg   <= 20'd655;
            dmin_reg     <= 24'sd0;
            dmax_reg     <= 24'sd65535;
        end else begin
            // Configuration writes.
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    pisc_pkg::CFG_PROP_GAIN:     kp_reg     <= cfg_data;
                    pisc_pkg::CFG_INTEGRAL_GAIN: ki_reg     <= cfg_data;
                    pisc_pkg::CFG_SAMPLE_PERIOD: period_reg <= cfg_data[19:0];
                    pisc_pkg::CFG_DRIVE_MIN:     dmin_reg   <= cfg_data;
                    pisc_pkg::CFG_DRIVE_MAX:     dmax_reg   <= cfg_data;
                    default: ;
                endcase
            end

            // The last step loads a new result itself when the old one leaves.
            if (m_valid_reg && m_tready && (state_reg != ST_DRIVE)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        err_reg    <= in_err;
                        es_abs_reg <= in_es_abs[16:0];
                        es_neg_reg <= in_es[17];
                        pwm_reg    <= s_tdata[47:32];
                        fault_reg  <= (in_dsr == 16'sd0);
                        rneg_reg   <= in_err[16] ^ in_dsr[15];
                        state_reg  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        ratio_reg <= fault_reg ? 32'd0 : div_quo;
                        state_reg <= ST_GAIN;
                    end
                end
                ST_GAIN: begin
                    gain_reg  <= mul_p[55:16];
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    a_reg     <= rneg_reg ? (42'sd65536 - $signed({2'b0, gain_reg}))
                                          : (42'sd65536 + $signed({2'b0, gain_reg}));
                    state_reg <= ST_PROP;
                end
                ST_PROP: begin
                    pmag_reg  <= mul_p[56:16];
                    pneg_reg  <= a_reg[41];
                    state_reg <= ST_PSAT;
                end
                ST_PSAT: begin
                    // Saturate the proportional term to the signed 24-bit range.
                    if (!pneg_reg) begin
                        prop_reg <= (pmag_reg > 41'd8388607) ? 24'sh7FFFFF : pmag_reg[23:0];
                    end else begin
                        prop_reg <= (pmag_reg > 41'd8388608) ? 24'sh800000
                                                             : 24'(41'd0 - pmag_reg);
                    end
                    state_reg <= ST_KT;
                end
                ST_KT: begin
                    kt_reg    <= mul_p[43:16];
                    state_reg <= ST_KTP;
                end
                ST_KTP: begin
                    ktp_reg   <= mul_p[43:0];
                    state_reg <= ST_DELTA;
                end
                ST_DELTA: begin
                    delta_reg <= mul_p[60:9];
                    state_reg <= ST_INTEG;
                end
                ST_INTEG: begin
                    sum_reg   <= sum_next;
                    lhi_reg   <= (dmax_reg > prop_reg) ? hi_diff : 25'sd0;
                    llo_reg   <= (dmin_reg < prop_reg) ? lo_diff : 25'sd0;
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    // Clamp the integrator to the room left by the proportional term.
                    priority if (sum_reg > hi_q) begin
                        integ_reg   <= hi_q[47:0];
                        clamped_reg <= 1'b1;
                    end else if (sum_reg < lo_q) begin
                        integ_reg   <= lo_q[47:0];
                        clamped_reg <= 1'b1;
                    end else begin
                        integ_reg   <= sum_reg[47:0];
                        clamped_reg <= 1'b0;
                    end
                    state_reg <= ST_DRIVE;
                end
                ST_DRIVE: begin
                    // Hold until the output register is free.
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg  <= 1'b1;
                        drive_reg    <= drv_sat;
                        ofault_reg   <= fault_reg;
                        oclamp_reg   <= clamped_reg;
                        last_err_reg <= err_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'd0, oclamp_reg, ofault_reg, drive_reg};

    // A request keeps the block busy in the cycle after its acceptance.
    `PISC_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready, "ready right after accept")
    // The divider runs only while the sequencer waits for it.
    `PISC_ASSERT_SAME(a_div_in_step, div_stat.busy, state_reg == ST_DIV, "divider busy out of step")
    // A zero divisor gives a zero ratio.
    `PISC_ASSERT_SAME(a_fault_ratio, (state_reg == ST_GAIN) && fault_reg, ratio_reg == 32'd0,
        "nonzero ratio on divide fault")
    // With ordered limits the drive lies between them.
    `PISC_ASSERT_SAME(a_drive_range, m_valid_reg && (dmin_reg <= dmax_reg),
        (drive_reg >= dmin_reg) && (drive_reg <= dmax_reg), "drive outside limits")

endmodule
